/* src/rgbenc_pkg.sv */
`default_nettype none

package rgbenc_pkg;

   // Strip geometry
   localparam int PIXEL_COUNT = 64;
   localparam int INDEX_WIDTH = 6;
   localparam int INDEX_COUNT = 2 ** INDEX_WIDTH;
   localparam logic [10:0] PIXEL_LIMIT = 11'(PIXEL_COUNT);

   // Pixel color layout and serializer
   localparam int COLOR_WIDTH = 24;
   localparam int BIT_COUNT_WIDTH = 5;
   localparam logic [BIT_COUNT_WIDTH-1:0] LAST_BIT_INDEX = BIT_COUNT_WIDTH'(COLOR_WIDTH - 1);

   // Color wheel segment limits
   localparam logic [7:0] WHEEL_THIRD = 8'd85;
   localparam logic [7:0] WHEEL_TWO_THIRDS = 8'd170;
   localparam logic [7:0] WHEEL_FULL = 8'd255;

   // Register reset values
   localparam logic [7:0] DUTY_ONE_RESET = 8'd60;
   localparam logic [7:0] DUTY_ZERO_RESET = 8'd30;

   typedef enum logic [1:0] {
      MODE_SOLID   = 2'd0,
      MODE_RAINBOW = 2'd1,
      MODE_SPREAD  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      REG_MODE        = 2'd0,
      REG_SOLID_COLOR = 2'd1,
      REG_DUTY_ONE    = 2'd2,
      REG_DUTY_ZERO   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic                   valid;
      logic [COLOR_WIDTH-1:0] color;
   } color_beat_type;

   typedef logic [INDEX_COUNT-1:0][7:0] spread_table_type;

   // Wheel offset of each pixel when the wheel is spread over the whole strip
   function automatic spread_table_type build_spread_table();
      spread_table_type t;
      for (int i = 0; i < INDEX_COUNT; i++) begin
         t[i] = 8'((i * 256) / PIXEL_COUNT);
      end
      return t;
   endfunction

   localparam spread_table_type SPREAD_TABLE = build_spread_table();

   // Three times a value of at most 85, which always fits in a byte
   function automatic logic [7:0] times_three(input logic [7:0] v);
      logic [9:0] sum;
      sum = {2'b00, v} + {1'b0, v, 1'b0};
      return sum[7:0];
   endfunction

   // Color wheel, packed green, red, blue
   function automatic logic [COLOR_WIDTH-1:0] wheel(input logic [7:0] pos);
      logic [7:0] w;
      logic [7:0] up;
      logic [7:0] down;
      w = WHEEL_FULL - pos;
      if (w < WHEEL_THIRD) begin
         up = times_three(w);
         down = WHEEL_FULL - up;
         return {8'd0, down, up};
      end else if (w < WHEEL_TWO_THIRDS) begin
         up = times_three(w - WHEEL_THIRD);
         down = WHEEL_FULL - up;
         return {up, 8'd0, down};
      end else begin
         up = times_three(w - WHEEL_TWO_THIRDS);
         down = WHEEL_FULL - up;
         return {down, up, 8'd0};
      end
   endfunction

endpackage

`default_nettype wire

/* src/rgbenc_color.sv */
`default_nettype none

module rgbenc_color (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    item_valid,
   output logic                                   item_ready,
   input  wire  [rgbenc_pkg::INDEX_WIDTH-1:0]     pixel_index,
   input  wire                                    advance_phase,
   input  wire  [1:0]                             mode,
   input  wire  [rgbenc_pkg::COLOR_WIDTH-1:0]     solid_color,
   output rgbenc_pkg::color_beat_type             color_out,
   input  wire                                    color_ready
);
   import rgbenc_pkg::*;

   logic [7:0]             phase_cnt_ff, phase_cnt_in;
   logic                   a_valid_ff, a_valid_in;
   logic [INDEX_WIDTH-1:0] a_index_ff;
   logic [7:0]             a_phase_ff;
   logic                   b_valid_ff, b_valid_in;
   logic [COLOR_WIDTH-1:0] b_color_ff, b_color_in;
   logic                   accept;
   logic                   b_ready;
   logic                   a_in_range;
   logic [7:0]             wheel_pos;

   assign b_ready = !b_valid_ff || color_ready;
   assign item_ready = !a_valid_ff || b_ready;
   assign accept = item_valid && item_ready;

   // advance the phase before this pixel sees it
   assign phase_cnt_in = accept ? (phase_cnt_ff + {7'd0, advance_phase}) : phase_cnt_ff;

   assign a_valid_in = item_ready ? item_valid : a_valid_ff;
   assign a_in_range = {{(11 - INDEX_WIDTH){1'b0}}, a_index_ff} < PIXEL_LIMIT;

   always_comb begin
      if (mode_type'(mode) == MODE_SPREAD) begin
         wheel_pos = SPREAD_TABLE[a_index_ff] + a_phase_ff;
      end else begin
         wheel_pos = {{(8 - INDEX_WIDTH){1'b0}}, a_index_ff} + a_phase_ff;
      end
   end

   always_comb begin
      unique case (mode_type'(mode))
         MODE_RAINBOW, MODE_SPREAD: b_color_in = wheel(wheel_pos);
         default:                   b_color_in = solid_color;
      endcase
   end

   // drop pixels beyond the strip here
   assign b_valid_in = b_ready ? (a_valid_ff && a_in_range) : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_cnt_ff <= 8'd0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         phase_cnt_ff <= phase_cnt_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_index_ff <= pixel_index;
         a_phase_ff <= phase_cnt_in;
      end
      if (b_ready) begin
         b_color_ff <= b_color_in;
      end
   end

   assign color_out = {b_valid_ff, b_color_ff};

`ifndef SYNTH
   a_phase_step: assert property (@(posedge clock) disable iff (reset)
      accept && advance_phase |=> phase_cnt_ff == $past(phase_cnt_ff) + 8'd1)
      else $error("phase did not advance on a flagged pixel");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(phase_cnt_ff))
      else $error("phase moved without an accepted pixel");
`endif

endmodule

`default_nettype wire

/* src/rgbenc_serializer.sv */
`default_nettype none

module rgbenc_serializer (
   input  wire                                    clock,
   input  wire                                    reset,
   input  rgbenc_pkg::color_beat_type             color_in,
   output logic                                   color_ready,
   input  wire  [7:0]                             duty_one,
   input  wire  [7:0]                             duty_zero,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [7:0]                             rsp_tdata,
   output logic                                   rsp_tlast
);
   import rgbenc_pkg::*;

   logic                       busy_ff, busy_in;
   logic [COLOR_WIDTH-1:0]     shift_ff, shift_in;
   logic [BIT_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                       send;
   logic                       load;

   assign send = busy_ff && rsp_tready;
   assign rsp_tlast = count_ff == LAST_BIT_INDEX;
   // take the next color on the same edge that sends the last beat
   assign load = !busy_ff || (rsp_tready && rsp_tlast);
   assign color_ready = load;

   always_comb begin
      busy_in = busy_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      if (load) begin
         busy_in = color_in.valid;
         shift_in = color_in.color;
         count_in = '0;
      end else if (send) begin
         shift_in = {shift_ff[COLOR_WIDTH-2:0], 1'b0};
         count_in = count_ff + BIT_COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata = shift_ff[COLOR_WIDTH-1] ? duty_one : duty_zero;

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LAST_BIT_INDEX)
      else $error("bit counter ran past the last bit");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load && color_in.valid |=> rsp_tvalid && count_ff == '0)
      else $error("loaded color did not start at the first bit");

   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast && !color_in.valid |=> !rsp_tvalid)
      else $error("serializer stayed busy with nothing loaded");
`endif

endmodule

`default_nettype wire

/* src/rgb_led_rainbow_bit_encoder_top.sv */
// RGB LED rainbow bit encoder.
// Input channel (req_): one beat per pixel slot. req_tdata carries pixel_index,
// req_tuser carries advance_phase, which bumps the 8-bit animation phase before
// this pixel is colored. Pixels at or beyond the strip length still move the
// phase but produce no output.
// Output channel (rsp_): 24 beats per pixel, green, red, blue, MSB first; each
// beat is the one-duty or zero-duty compare value, rsp_tlast on the 24th.
// Config channel (csr_): always ready; index 0 mode, 1 solid color, 2 one-duty,
// 3 zero-duty. Write only while the block is idle.
// Path: input register, color register, then the serializer shift register.
// Throughput: one beat per cycle out of the serializer shift register while
// rsp_tready is high; the next pixel is colored and held in a two-deep input
// pipeline meanwhile, so back-to-back pixels stream without gaps.
// Stall: when rsp_tready is low the current beat holds; the pipeline fills and
// then req_tready drops until the serializer frees a slot.
// Reset: phase 0, mode solid, solid color 0, one-duty 60, zero-duty 30; all
// pending pixels are discarded.
`default_nettype none

module rgb_led_rainbow_bit_encoder_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [5:0] pixel_index, [7:6] zero
   input  wire         req_tuser,   // [0] advance_phase
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] duty_word
   output logic        rsp_tlast,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [23:0] csr_data
);
   import rgbenc_pkg::*;

   logic [1:0]             mode_ff;
   logic [COLOR_WIDTH-1:0] solid_color_ff;
   logic [7:0]             duty_one_ff;
   logic [7:0]             duty_zero_ff;
   color_beat_type         color_beat;
   logic                   color_ready;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SOLID;
         solid_color_ff <= '0;
         duty_one_ff <= DUTY_ONE_RESET;
         duty_zero_ff <= DUTY_ZERO_RESET;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_MODE:        mode_ff <= csr_data[1:0];
            REG_SOLID_COLOR: solid_color_ff <= csr_data[COLOR_WIDTH-1:0];
            REG_DUTY_ONE:    duty_one_ff <= csr_data[7:0];
            REG_DUTY_ZERO:   duty_zero_ff <= csr_data[7:0];
         endcase
      end
   end

   // phase, input register and color lookup
   rgbenc_color u_color (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (req_tvalid),
      .item_ready    (req_tready),
      .pixel_index   (req_tdata[INDEX_WIDTH-1:0]),
      .advance_phase (req_tuser),
      .mode          (mode_ff),
      .solid_color   (solid_color_ff),
      .color_out     (color_beat),
      .color_ready   (color_ready)
   );

   // shift the color out one duty word per beat
   rgbenc_serializer u_serializer (
      .clock       (clock),
      .reset       (reset),
      .color_in    (color_beat),
      .color_ready (color_ready),
      .duty_one    (duty_one_ff),
      .duty_zero   (duty_zero_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire
